// ===== design/ptc_pkg.sv =====
// Shared types and constants for the pressure and temperature compensation pipeline.
// No dependencies; every other design file imports this package.
`default_nettype none

package ptc_pkg;

	// Error codes, in the order the checks are applied
	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_RAW_P = 3'd1,
		ERR_RAW_T = 3'd2,
		ERR_DT    = 3'd3,
		ERR_OFF   = 3'd4,
		ERR_SENS  = 3'd5,
		ERR_PRESS = 3'd6
	} err_t;

	// Configuration register indexes
	localparam logic [2:0] REG_SENS        = 3'd0;
	localparam logic [2:0] REG_OFFSET      = 3'd1;
	localparam logic [2:0] REG_SENS_TCO    = 3'd2;
	localparam logic [2:0] REG_OFFSET_TCO  = 3'd3;
	localparam logic [2:0] REG_REF_TEMP    = 3'd4;

	// Coefficient reset values
	localparam logic [15:0] C1_RST = 16'd46372;
	localparam logic [15:0] C2_RST = 16'd43981;
	localparam logic [15:0] C3_RST = 16'd29059;
	localparam logic [15:0] C4_RST = 16'd27842;
	localparam logic [15:0] C5_RST = 16'd31553;

	// Range limits
	localparam logic [24:0]        RAW_LIMIT = 25'd16777216;
	localparam logic signed [25:0] DT_LOW    = -26'sd16776960;
	localparam logic signed [25:0] DT_HIGH   = 26'sd16777216;
	localparam logic signed [37:0] OFF_LOW   = -38'sd17179344900;
	localparam logic signed [37:0] OFF_HIGH  = 38'sd25769410560;
	localparam logic signed [37:0] SENS_LOW  = -38'sd8589672450;
	localparam logic signed [37:0] SENS_HIGH = 38'sd12884705280;
	localparam logic signed [25:0] P_LOW     = 26'sd1000;
	localparam logic signed [25:0] P_HIGH    = 26'sd120000;

	// Reciprocal of 100 scaled by 2^24 (rounded up); exact for p below 2^24/84
	localparam logic [17:0] RECIP_100 = 18'd167773;
	localparam int          RECIP_SHIFT = 24;

	// Calibration coefficients
	typedef struct packed {
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c3;
		logic [15:0] c4;
		logic [15:0] c5;
	} coef_t;

	// Temperature difference front end result
	typedef struct packed {
		err_t               err;
		logic [24:0]        d1;
		logic signed [41:0] off_prod;
		logic signed [41:0] sens_prod;
	} tdiff_t;

	// Offset and sensitivity stage result
	typedef struct packed {
		err_t               err;
		logic signed [37:0] off;
		logic [42:0]        pp_lo;
		logic signed [42:0] pp_hi;
	} osens_t;

	// Pressure stage result
	typedef struct packed {
		err_t        err;
		logic [34:0] scaled;
	} press_t;

endpackage

`default_nettype wire

// ===== design/ptc_tdiff.sv =====
// Stages 1-2: temperature difference, raw and dT range checks and tempco products.
// Depends on ptc_pkg.
`default_nettype none

module ptc_tdiff
	import ptc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [24:0] raw_pressure,
	input  wire  [24:0] raw_temperature,
	input  coef_t       coef,
	output logic        out_valid,
	input  wire         out_ready,
	output tdiff_t      out_data
);

	logic               v_s1, v_s2;
	logic               rdy_s1, rdy_s2;
	err_t               err_s1;
	logic [24:0]        d1_s1;
	logic signed [25:0] dt_s1;
	tdiff_t             data_s2;

	logic signed [25:0] dt;
	err_t               err_raw;
	err_t               err_dt;

	// stall chain
	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// dT = D2 - C5 * 2^8, raw limits
	assign dt = $signed({1'b0, raw_temperature}) - $signed({2'b00, coef.c5, 8'h00});

	always_comb begin
		if (raw_pressure > RAW_LIMIT) begin
			err_raw = ERR_RAW_P;
		end else if (raw_temperature > RAW_LIMIT) begin
			err_raw = ERR_RAW_T;
		end else begin
			err_raw = ERR_NONE;
		end
	end

	always_comb begin
		if (err_s1 != ERR_NONE) begin
			err_dt = err_s1;
		end else if (dt_s1 < DT_LOW || dt_s1 > DT_HIGH) begin
			err_dt = ERR_DT;
		end else begin
			err_dt = ERR_NONE;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			err_s1 <= err_raw;
			d1_s1  <= raw_pressure;
			dt_s1  <= dt;
		end
	end

	// stage 2: C4 * dT and C3 * dT
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			data_s2.err       <= err_dt;
			data_s2.d1        <= d1_s1;
			data_s2.off_prod  <= $signed({1'b0, coef.c4}) * dt_s1;
			data_s2.sens_prod <= $signed({1'b0, coef.c3}) * dt_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

// ===== design/ptc_offsens.sv =====
// Stages 3-4: offset and sensitivity, their range checks, and the split
// partial products of D1 * SENS. Depends on ptc_pkg.
`default_nettype none

module ptc_offsens
	import ptc_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	input  wire    in_valid,
	output logic   in_ready,
	input  tdiff_t in_data,
	input  coef_t  coef,
	output logic   out_valid,
	input  wire    out_ready,
	output osens_t out_data
);

	logic               v_s3, v_s4;
	logic               rdy_s3, rdy_s4;
	err_t               err_s3;
	logic [24:0]        d1_s3;
	logic signed [37:0] off_s3;
	logic signed [37:0] sens_s3;
	osens_t             data_s4;

	logic signed [37:0] off;
	logic signed [37:0] sens;
	err_t               err_os;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	// OFF = C2 * 2^17 + floor(C4 * dT / 2^6), SENS = C1 * 2^16 + floor(C3 * dT / 2^7)
	assign off  = $signed({5'd0, coef.c2, 17'd0})
		+ $signed({{2{in_data.off_prod[41]}}, in_data.off_prod[41:6]});
	assign sens = $signed({6'd0, coef.c1, 16'd0})
		+ $signed({{3{in_data.sens_prod[41]}}, in_data.sens_prod[41:7]});

	always_comb begin
		if (err_s3 != ERR_NONE) begin
			err_os = err_s3;
		end else if (off_s3 < OFF_LOW || off_s3 > OFF_HIGH) begin
			err_os = ERR_OFF;
		end else if (sens_s3 < SENS_LOW || sens_s3 > SENS_HIGH) begin
			err_os = ERR_SENS;
		end else begin
			err_os = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= in_valid;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			err_s3  <= in_data.err;
			d1_s3   <= in_data.d1;
			off_s3  <= off;
			sens_s3 <= sens;
		end
	end

	// in range SENS fits 35 bits: low 18 unsigned, high 17 signed
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			data_s4.err   <= err_os;
			data_s4.off   <= off_s3;
			data_s4.pp_lo <= {18'd0, d1_s3} * {25'd0, sens_s3[17:0]};
			data_s4.pp_hi <= $signed({1'b0, d1_s3}) * $signed(sens_s3[34:18]);
		end
	end

	assign out_valid = v_s4;
	assign out_data  = data_s4;

endmodule

`default_nettype wire

// ===== design/ptc_press.sv =====
// Stages 5-7: product recombination, pressure in pascal, range check and
// scaling by the reciprocal of 100. Depends on ptc_pkg.
`default_nettype none

module ptc_press
	import ptc_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	input  wire    in_valid,
	output logic   in_ready,
	input  osens_t in_data,
	output logic   out_valid,
	input  wire    out_ready,
	output press_t out_data
);

	logic               v_s5, v_s6, v_s7;
	logic               rdy_s5, rdy_s6, rdy_s7;
	err_t               err_s5, err_s6;
	logic signed [60:0] prod_s5;
	logic signed [37:0] off_s5;
	logic signed [25:0] p_s6;
	press_t             data_s7;

	logic signed [40:0] diff;
	err_t               err_p;

	assign rdy_s7   = !v_s7 || out_ready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign in_ready = rdy_s5;

	// floor(D1 * SENS / 2^21) - OFF
	assign diff = $signed({prod_s5[60], prod_s5[60:21]})
		- $signed({{3{off_s5[37]}}, off_s5});

	always_comb begin
		if (err_s6 != ERR_NONE) begin
			err_p = err_s6;
		end else if (p_s6 < P_LOW || p_s6 > P_HIGH) begin
			err_p = ERR_PRESS;
		end else begin
			err_p = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= in_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	// stage 5: D1 * SENS from the two partial products
	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			err_s5  <= in_data.err;
			off_s5  <= in_data.off;
			prod_s5 <= $signed({in_data.pp_hi, 18'd0}) + $signed({18'd0, in_data.pp_lo});
		end
	end

	// stage 6: pressure in pascal
	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			err_s6 <= err_s5;
			p_s6   <= diff[40:15];
		end
	end

	// stage 7: range check, p * ceil(2^24 / 100)
	always_ff @(posedge clk) begin
		if (rdy_s7 && v_s6) begin
			data_s7.err    <= err_p;
			data_s7.scaled <= {18'd0, p_s6[16:0]} * {17'd0, RECIP_100};
		end
	end

	assign out_valid = v_s7;
	assign out_data  = data_s7;

endmodule

`default_nettype wire

// ===== design/pressure_temperature_compensation.sv =====
// Pressure and temperature compensation, top level: coefficient registers,
// pipeline sections and the output register. Depends on ptc_pkg, ptc_tdiff,
// ptc_offsens and ptc_press.
//
// One raw pressure / raw temperature pair goes in per item and one result
// comes out per item, in order. The block takes one item every clock cycle
// while the output is not stalled, through eight register stages; the two
// tempco products sit in stage 2, the two partial products of D1 * SENS in
// stage 4 and the multiplier by the reciprocal of 100 in stage 7. Every
// stage holds its item while the next is full, so output back-pressure stalls
// only as far back as needed. Coefficients are written through the cfg channel
// (always ready) and should only change while no item is in flight.
`default_nettype none

module pressure_temperature_compensation
	import ptc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	// input items
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [55:0] s_tdata,   // [24:0] raw_pressure, [49:25] raw_temperature, [55:50] zero
	// result items
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [10:0] pressure_mbar, [15:11] zero
	output logic [3:0]  m_tuser,   // [0] valid_res, [3:1] error_code
	// coefficient writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	coef_t       coef_q;
	logic        td_valid, td_ready;
	tdiff_t      td_data;
	logic        os_valid, os_ready;
	osens_t      os_data;
	logic        pr_valid, pr_ready;
	press_t      pr_data;
	logic        v_s8;
	err_t        err_s8;
	logic [10:0] mbar_s8;

	// coefficient registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.c1 <= C1_RST;
			coef_q.c2 <= C2_RST;
			coef_q.c3 <= C3_RST;
			coef_q.c4 <= C4_RST;
			coef_q.c5 <= C5_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SENS:       coef_q.c1 <= cfg_data;
				REG_OFFSET:     coef_q.c2 <= cfg_data;
				REG_SENS_TCO:   coef_q.c3 <= cfg_data;
				REG_OFFSET_TCO: coef_q.c4 <= cfg_data;
				REG_REF_TEMP:   coef_q.c5 <= cfg_data;
				default:        ;
			endcase
		end
	end

	ptc_tdiff u_tdiff (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.raw_pressure    (s_tdata[24:0]),
		.raw_temperature (s_tdata[49:25]),
		.coef            (coef_q),
		.out_valid       (td_valid),
		.out_ready       (td_ready),
		.out_data        (td_data)
	);

	ptc_offsens u_offsens (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (td_valid),
		.in_ready  (td_ready),
		.in_data   (td_data),
		.coef      (coef_q),
		.out_valid (os_valid),
		.out_ready (os_ready),
		.out_data  (os_data)
	);

	ptc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (os_valid),
		.in_ready  (os_ready),
		.in_data   (os_data),
		.out_valid (pr_valid),
		.out_ready (pr_ready),
		.out_data  (pr_data)
	);

	// output register: millibar from the scaled product, zero on error
	assign pr_ready = !v_s8 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (pr_ready) begin
			v_s8 <= pr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pr_ready && pr_valid) begin
			err_s8 <= pr_data.err;
			if (pr_data.err == ERR_NONE) begin
				mbar_s8 <= pr_data.scaled[RECIP_SHIFT+10:RECIP_SHIFT];
			end else begin
				mbar_s8 <= 11'd0;
			end
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata  = {5'd0, mbar_s8};
	assign m_tuser  = {err_s8, (err_s8 == ERR_NONE)};

	// a valid result carries no error code and a pressure in range
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[10:0] >= 11'd10 && m_tdata[10:0] <= 11'd1200))
		else $error("valid result with pressure out of range");

	// a failed result reports zero pressure
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0))
		else $error("failed result with nonzero pressure");

	// with the output register empty the whole pipeline can move
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// an item leaving stage 7 while the output is taken lands in the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(pr_valid && m_tready) |=> m_tvalid)
		else $error("result lost at output register");

endmodule

`default_nettype wire
